### design/rrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types, codes and defaults of the rectangle raster painter.
// ----------------------------------------------------------------------------
package rrp_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 8;

    localparam int COORD_W = 24;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 8;
    localparam int WIN_W   = 9;
    localparam int CFG_W   = 9;

    localparam logic [WIN_W-1:0]  RST_FRAME_WIDTH  = 9'd256;
    localparam logic [WIN_W-1:0]  RST_FRAME_HEIGHT = 9'd256;
    localparam logic [CHAR_W-1:0] RST_BACKGROUND   = 8'd32;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_DRAW  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BADSIZE = 2'd1,
        STAT_OUTSIDE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BACKGROUND   = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_SCAN     = 4'b0010,
        S_RD_ISSUE = 4'b0100,
        S_RD_WAIT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] rect_left;
        logic signed [COORD_W-1:0] rect_top;
        logic signed [COORD_W-1:0] rect_width;
        logic signed [COORD_W-1:0] rect_height;
        logic                      outline_only;
        logic [CHAR_W-1:0]         paint_char;
        logic [POS_W-1:0]          read_col;
        logic [POS_W-1:0]          read_row;
    } cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0] pixel_char;
        logic [1:0]        status;
    } rsp_t;

endpackage

### design/rrp_frame_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_frame_mem
// Character frame store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rrp_frame_mem #(
    parameter int DEPTH  = rrp_pkg::DEF_MAX_WIDTH * rrp_pkg::DEF_MAX_HEIGHT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [rrp_pkg::CHAR_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [rrp_pkg::CHAR_W-1:0] rd_data
);
    import rrp_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/rrp_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_scanner
// Command sequencer: walks the window for clear and draw, at most one store
// write per pixel, and runs the store read for read commands.
// ----------------------------------------------------------------------------
module rrp_scanner #(
    parameter int MAX_WIDTH  = rrp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rrp_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = rrp_pkg::DEF_FRAC_BITS,
    parameter int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    parameter int ADDR_W     = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                               $clog2(MAX_WIDTH * MAX_HEIGHT) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  rrp_pkg::cmd_t              cmd,
    output logic                       busy,
    output logic                       done,
    output rrp_pkg::rsp_t              result,
    input  logic [COL_W-1:0]           win_col_last,
    input  logic [ROW_W-1:0]           win_row_last,
    input  logic [rrp_pkg::CHAR_W-1:0] bg_char,
    output logic                       wr_en,
    output logic [ADDR_W-1:0]          wr_addr,
    output logic [rrp_pkg::CHAR_W-1:0] wr_data,
    output logic                       rd_en,
    output logic [ADDR_W-1:0]          rd_addr,
    input  logic [rrp_pkg::CHAR_W-1:0] rd_data
);
    import rrp_pkg::*;

    localparam int PIX_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + FRAC_BITS + 1;
    localparam int FX_W  = ((PIX_W > COORD_W + 2) ? PIX_W : COORD_W + 2) + 1;
    localparam int RC_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) > POS_W ?
                           ((COL_W > ROW_W) ? COL_W : ROW_W) : POS_W;
    localparam logic signed [FX_W-1:0] ONE = FX_W'(1) << FRAC_BITS;

    state_t state_reg, state_next;
    logic done_reg, done_next;
    rsp_t result_reg, result_next;

    logic [COL_W-1:0]  col_reg, col_next, col_last_reg, col_last_next;
    logic [ROW_W-1:0]  row_reg, row_next, row_last_reg, row_last_next;
    logic [ADDR_W-1:0] base_reg, base_next, addr_reg, addr_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic fill_all_reg, fill_all_next, outline_reg, outline_next;

    // rectangle bounds and the inner edges of the outline band
    logic signed [FX_W-1:0] xl_reg, xr_reg, xlo_reg, xro_reg;
    logic signed [FX_W-1:0] yt_reg, yb_reg, yto_reg, ybo_reg;
    logic signed [FX_W-1:0] xl_next, xr_next, xlo_next, xro_next;
    logic signed [FX_W-1:0] yt_next, yb_next, yto_next, ybo_next;

    logic signed [FX_W-1:0] cmd_l, cmd_t_y, cmd_w, cmd_h, px, py;
    logic size_ok, in_window, in_rect, on_band, covered, last_col, last_row;
    logic accept;

    assign accept = start && (state_reg == S_IDLE);

    assign cmd_l   = {{(FX_W-COORD_W){cmd.rect_left[COORD_W-1]}}, cmd.rect_left};
    assign cmd_t_y = {{(FX_W-COORD_W){cmd.rect_top[COORD_W-1]}}, cmd.rect_top};
    assign cmd_w   = {{(FX_W-COORD_W){cmd.rect_width[COORD_W-1]}}, cmd.rect_width};
    assign cmd_h   = {{(FX_W-COORD_W){cmd.rect_height[COORD_W-1]}}, cmd.rect_height};

    assign size_ok = !cmd.rect_width[COORD_W-1] && (cmd.rect_width != '0) &&
                     !cmd.rect_height[COORD_W-1] && (cmd.rect_height != '0);

    assign in_window = (RC_W'(cmd.read_col) <= RC_W'(win_col_last)) &&
                       (RC_W'(cmd.read_row) <= RC_W'(win_row_last));

    assign px = $signed(FX_W'(col_reg) << FRAC_BITS);
    assign py = $signed(FX_W'(row_reg) << FRAC_BITS);

    assign in_rect = (px >= xl_reg) && (px <= xr_reg) && (py >= yt_reg) && (py <= yb_reg);
    assign on_band = (px < xlo_reg) || (px > xro_reg) || (py < yto_reg) || (py > ybo_reg);
    assign covered = fill_all_reg || (in_rect && (!outline_reg || on_band));

    assign last_col = (col_reg == col_last_reg);
    assign last_row = (row_reg == row_last_reg);

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        base_next     = base_reg;
        addr_next     = addr_reg;
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        char_next     = char_reg;
        fill_all_next = fill_all_reg;
        outline_next  = outline_reg;
        xl_next  = xl_reg;
        xr_next  = xr_reg;
        xlo_next = xlo_reg;
        xro_next = xro_reg;
        yt_next  = yt_reg;
        yb_next  = yb_reg;
        yto_next = yto_reg;
        ybo_next = ybo_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next   = '0;
                    col_next      = '0;
                    row_next      = '0;
                    base_next     = '0;
                    col_last_next = win_col_last;
                    row_last_next = win_row_last;
                    outline_next  = cmd.outline_only;
                    xl_next  = cmd_l;
                    xr_next  = cmd_l + cmd_w;
                    xlo_next = cmd_l + ONE;
                    xro_next = cmd_l + cmd_w - ONE;
                    yt_next  = cmd_t_y;
                    yb_next  = cmd_t_y + cmd_h;
                    yto_next = cmd_t_y + ONE;
                    ybo_next = cmd_t_y + cmd_h - ONE;
                    case (cmd.req_type)
                        REQ_CLEAR:
                        begin
                            fill_all_next = 1'b1;
                            char_next     = bg_char;
                            state_next    = S_SCAN;
                        end
                        REQ_DRAW:
                        begin
                            fill_all_next = 1'b0;
                            char_next     = cmd.paint_char;
                            if (size_ok)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                result_next.status = STAT_BADSIZE;
                                done_next          = 1'b1;
                            end
                        end
                        REQ_READ:
                        begin
                            if (in_window)
                            begin
                                addr_next = ADDR_W'(cmd.read_row) * ADDR_W'(MAX_WIDTH)
                                          + ADDR_W'(cmd.read_col);
                                state_next = S_RD_ISSUE;
                            end
                            else
                            begin
                                result_next.status = STAT_OUTSIDE;
                                done_next          = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (last_col)
                begin
                    col_next  = '0;
                    row_next  = row_reg + 1'b1;
                    base_next = base_reg + ADDR_W'(MAX_WIDTH);
                    if (last_row)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_RD_ISSUE:
            begin
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                result_next.pixel_char = rd_data;
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg   <= result_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        base_reg     <= base_next;
        addr_reg     <= addr_next;
        col_last_reg <= col_last_next;
        row_last_reg <= row_last_next;
        char_reg     <= char_next;
        fill_all_reg <= fill_all_next;
        outline_reg  <= outline_next;
        xl_reg  <= xl_next;
        xr_reg  <= xr_next;
        xlo_reg <= xlo_next;
        xro_reg <= xro_next;
        yt_reg  <= yt_next;
        yb_reg  <= yb_next;
        yto_reg <= yto_next;
        ybo_reg <= ybo_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign result  = result_reg;

    assign wr_en   = (state_reg == S_SCAN) && covered;
    assign wr_addr = base_reg + ADDR_W'(col_reg);
    assign wr_data = char_reg;
    assign rd_en   = (state_reg == S_RD_ISSUE);
    assign rd_addr = addr_reg;

endmodule

### design/rectangle_raster_painter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_raster_painter
// Character frame store with clear, rectangle draw and pixel read commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result
// shows on result with done high for a single cycle and cannot be held off.
// Clear and draw walk the window row by row through the single store write
// port, one pixel per cycle, before their result comes. A read goes through
// the issue and wait states and the registered store read port. A draw with
// a bad size, a read outside the window and an unknown command answer in the
// next cycle. A new command may be issued in the cycle that done is high.
// Issue a clear before the first read; the user must write window and
// background registers only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module rectangle_raster_painter #(
    parameter int MAX_WIDTH  = rrp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rrp_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = rrp_pkg::DEF_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  rrp_pkg::cmd_t             cmd,
    output logic                      busy,
    output logic                      done,
    output rrp_pkg::rsp_t             result,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_addr,
    input  logic [rrp_pkg::CFG_W-1:0] cfg_wdata
);
    import rrp_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WC_W   = ($clog2(MAX_WIDTH + 1) > WIN_W) ? $clog2(MAX_WIDTH + 1) : WIN_W;
    localparam int HC_W   = ($clog2(MAX_HEIGHT + 1) > WIN_W) ? $clog2(MAX_HEIGHT + 1) : WIN_W;

    logic [WIN_W-1:0]  frame_width_reg, frame_height_reg;
    logic [CHAR_W-1:0] background_reg;
    logic [COL_W-1:0]  col_last;
    logic [ROW_W-1:0]  row_last;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CHAR_W-1:0] wr_data, rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            background_reg   <= RST_BACKGROUND;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                CFG_BACKGROUND:   background_reg   <= cfg_wdata[CHAR_W-1:0];
                default:          ;
            endcase
        end
    end

    // zero acts as one, oversize as the store size
    always_comb
    begin
        if (frame_width_reg == '0)
            col_last = '0;
        else if (WC_W'(frame_width_reg) > WC_W'(MAX_WIDTH))
            col_last = COL_W'(MAX_WIDTH - 1);
        else
            col_last = COL_W'(frame_width_reg - 1'b1);

        if (frame_height_reg == '0)
            row_last = '0;
        else if (HC_W'(frame_height_reg) > HC_W'(MAX_HEIGHT))
            row_last = ROW_W'(MAX_HEIGHT - 1);
        else
            row_last = ROW_W'(frame_height_reg - 1'b1);
    end

    rrp_scanner #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W),
        .ADDR_W     (ADDR_W)
    ) u_scanner (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .done         (done),
        .result       (result),
        .win_col_last (col_last),
        .win_row_last (row_last),
        .bg_char      (background_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    rrp_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

### design/rrp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_checker
// Port-level checks of the rectangle raster painter, bound to the top level.
// ----------------------------------------------------------------------------
module rrp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input rrp_pkg::cmd_t cmd,
    input logic          busy,
    input logic          done,
    input rrp_pkg::rsp_t result
);
    import rrp_pkg::*;

    logic accept;
    assign accept = start && !busy;

    // leaving a busy stretch always delivers its result transfer
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // a clear always walks at least one pixel
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.req_type == REQ_CLEAR)) |=> (busy && !done))
        else $error("clear did not start a scan");

    a_bad_size: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.req_type == REQ_DRAW) &&
         (cmd.rect_width[COORD_W-1] || (cmd.rect_width == '0)))
        |=> (done && !busy && (result.status == STAT_BADSIZE)))
        else $error("bad rectangle size not reported at once");

    a_error_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != STAT_OK)) |-> (result.pixel_char == '0))
        else $error("error result carries a character");

endmodule

bind rectangle_raster_painter rrp_checker u_rrp_checker (.*);

### tb/rectangle_raster_painter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_raster_painter_test
// Self-checking testbench for the rectangle raster painter. A directed table
// covers reset values, window register limits, bad sizes, unknown commands,
// reads outside the window and extreme corners. Random phases follow. Each
// phase sets a new window and background, clears, then mixes draws, reads
// and noise. A shadow frame image predicts every result the table does not pin.
// ----------------------------------------------------------------------------
module rectangle_raster_painter_test;
    import rrp_pkg::*;

    localparam int MAXW = DEF_MAX_WIDTH;
    localparam int MAXH = DEF_MAX_HEIGHT;
    localparam int FRAC = DEF_FRAC_BITS;
    localparam int RAND_ITEMS = 76;

    typedef struct {
        bit             is_reg;
        cfg_idx_t       addr;
        logic [CFG_W-1:0] val;
        cmd_t           c;
        bit             fixed;
        rsp_t           rsp;
    } plan_row_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    cmd_t             cmd = '0;
    logic             busy;
    logic             done;
    rsp_t             result;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_addr = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // shadow of the block state
    bit [CHAR_W-1:0]  frame_img [0:MAXW*MAXH-1];
    logic [WIN_W-1:0] win_w_reg = RST_FRAME_WIDTH;
    logic [WIN_W-1:0] win_h_reg = RST_FRAME_HEIGHT;
    logic [CHAR_W-1:0] bg_reg   = RST_BACKGROUND;

    rsp_t      pending_rsp [$];
    plan_row_t plan_q [$];
    int        fail_count = 0;
    int        sent = 0;

    rectangle_raster_painter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("rectangle_raster_painter test failed");
        $finish;
    end

    function automatic int eff_dim(logic [WIN_W-1:0] v, int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // Applies one command to the shadow image and returns its result.
    function automatic rsp_t paint_predict(cmd_t c);
        rsp_t   r;
        int     ww;
        int     wh;
        longint l;
        longint t;
        longint rx;
        longint by;
        longint px;
        longint py;
        longint one;
        bit     hit;
        r   = '0;
        ww  = eff_dim(win_w_reg, MAXW);
        wh  = eff_dim(win_h_reg, MAXH);
        one = longint'(1) << FRAC;
        case (req_t'(c.req_type))
            REQ_CLEAR:
            begin
                for (int row = 0; row < wh; row++)
                    for (int col = 0; col < ww; col++)
                        frame_img[row*MAXW+col] = bg_reg;
            end
            REQ_DRAW:
            begin
                l  = $signed(c.rect_left);
                t  = $signed(c.rect_top);
                rx = $signed(c.rect_width);
                by = $signed(c.rect_height);
                if (rx <= 0 || by <= 0)
                begin
                    r.status = STAT_BADSIZE;
                end
                else
                begin
                    rx = l + rx;
                    by = t + by;
                    for (int row = 0; row < wh; row++)
                    begin
                        py = longint'(row) << FRAC;
                        for (int col = 0; col < ww; col++)
                        begin
                            px  = longint'(col) << FRAC;
                            hit = px >= l && px <= rx && py >= t && py <= by;
                            if (hit && c.outline_only)
                                hit = (px - l < one) || (rx - px < one) ||
                                      (py - t < one) || (by - py < one);
                            if (hit)
                                frame_img[row*MAXW+col] = c.paint_char;
                        end
                    end
                end
            end
            REQ_READ:
            begin
                if (c.read_col >= ww || c.read_row >= wh)
                    r.status = STAT_OUTSIDE;
                else
                    r.pixel_char = frame_img[c.read_row*MAXW+c.read_col];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void add_reg(cfg_idx_t a, int v);
        plan_row_t p;
        p        = '{addr: CFG_FRAME_WIDTH, default: '0};
        p.is_reg = 1'b1;
        p.addr   = a;
        p.val    = CFG_W'(v);
        plan_q.push_back(p);
    endfunction

    function automatic void add_cmd(req_t rq, int l, int t, int rw, int rh, bit ol,
                                    int ch, int col, int row);
        plan_row_t p;
        p                = '{addr: CFG_FRAME_WIDTH, default: '0};
        p.c.req_type     = rq;
        p.c.rect_left    = COORD_W'(l);
        p.c.rect_top     = COORD_W'(t);
        p.c.rect_width   = COORD_W'(rw);
        p.c.rect_height  = COORD_W'(rh);
        p.c.outline_only = ol;
        p.c.paint_char   = CHAR_W'(ch);
        p.c.read_col     = POS_W'(col);
        p.c.read_row     = POS_W'(row);
        plan_q.push_back(p);
    endfunction

    // pins the last command row to a known answer
    function automatic void known_rsp(int pix, status_t st);
        plan_q[$].fixed          = 1'b1;
        plan_q[$].rsp.pixel_char = CHAR_W'(pix);
        plan_q[$].rsp.status     = st;
    endfunction

    function automatic cmd_t random_cmd(bit first_clear);
        cmd_t         c;
        logic [127:0] raw;
        int           ww;
        int           wh;
        int           pick;
        raw  = {$urandom(), $urandom(), $urandom(), $urandom()};
        c    = raw[$bits(cmd_t)-1:0];
        ww   = eff_dim(win_w_reg, MAXW);
        wh   = eff_dim(win_h_reg, MAXH);
        pick = $urandom_range(99);
        if (first_clear)
        begin
            c.req_type = REQ_CLEAR;
        end
        else if (pick < 4)
        begin
            c.req_type = REQ_NONE;
        end
        else if (pick < 12)
        begin
            c.req_type = REQ_CLEAR;
        end
        else if (pick < 55)
        begin
            c.req_type = REQ_DRAW;
            // mostly rectangles near the window; the rest keeps raw noise
            if ($urandom_range(9) < 8)
            begin
                c.rect_left   = COORD_W'($urandom_range(0, (ww + 4) << FRAC) - 512);
                c.rect_top    = COORD_W'($urandom_range(0, (wh + 4) << FRAC) - 512);
                c.rect_width  = COORD_W'(($urandom_range(9) < 3) ? $urandom_range(1, 512)
                                         : $urandom_range(1, (ww + 2) << FRAC));
                c.rect_height = COORD_W'(($urandom_range(9) < 3) ? $urandom_range(1, 512)
                                         : $urandom_range(1, (wh + 2) << FRAC));
            end
        end
        else
        begin
            c.req_type = REQ_READ;
            if ($urandom_range(99) < 85)
            begin
                c.read_col = POS_W'($urandom_range(0, ww - 1));
                c.read_row = POS_W'($urandom_range(0, wh - 1));
            end
        end
        return c;
    endfunction

    task automatic issue_cmd(cmd_t c, bit fixed, rsp_t fixed_rsp, int idle_pct);
        rsp_t pred;
        int   gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 24) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        pred = paint_predict(c);
        pending_rsp.push_back(fixed ? fixed_rsp : pred);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0 || busy);
    endtask

    // leaves cfg_we high; the caller drops it after the last write
    task automatic reg_write(cfg_idx_t a, logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        case (a)
            CFG_FRAME_WIDTH:  win_w_reg = v;
            CFG_FRAME_HEIGHT: win_h_reg = v;
            CFG_BACKGROUND:   bg_reg    = v[CHAR_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_window(int w, int h, int bg);
        wait_idle();
        reg_write(CFG_FRAME_WIDTH, CFG_W'(w));
        reg_write(CFG_FRAME_HEIGHT, CFG_W'(h));
        reg_write(CFG_BACKGROUND, CFG_W'(bg));
        cfg_we <= 1'b0;
    endtask

    // result checker; done can't be held off so every strobe is a transfer
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result pixel_char %0d status %0d",
                             $realtime, result.pixel_char, result.status);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (result.pixel_char !== want.pixel_char || result.status !== want.status)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch pixel_char exp %0d got %0d, status exp %0d got %0d",
                                 $realtime, want.pixel_char, result.pixel_char,
                                 want.status, result.status);
                end
            end
        end
    end

    initial
    begin
        int   phase;
        int   w;
        int   h;
        int   n;
        int   pct;
        rsp_t none;
        none = '0;

        // reset window 256 x 256, background 32
        add_cmd(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);                  known_rsp(0, STAT_OK);
        add_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 255, 255);               known_rsp(32, STAT_OK);
        add_cmd(REQ_DRAW, 0, 0, 0, 256, 0, 8'h52, 0, 0);             known_rsp(0, STAT_BADSIZE);
        add_cmd(REQ_DRAW, 0, 0, 256, -8388608, 1, 8'h52, 0, 0);      known_rsp(0, STAT_BADSIZE);
        add_cmd(REQ_DRAW, 0, 0, -1, 8388607, 0, 8'h52, 0, 0);        known_rsp(0, STAT_BADSIZE);
        add_cmd(REQ_NONE, 8388607, -1, 8388607, -1, 1, 255, 255, 255); known_rsp(0, STAT_OK);
        // zero width acts as one column, oversize height as full height
        add_reg(CFG_FRAME_WIDTH, 0);
        add_reg(CFG_FRAME_HEIGHT, 511);
        add_reg(CFG_BACKGROUND, 255);
        add_cmd(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);                  known_rsp(0, STAT_OK);
        add_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 1, 0);                   known_rsp(0, STAT_OUTSIDE);
        add_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 255);                 known_rsp(255, STAT_OK);
        // most negative corner and largest size: right edge at -1, nothing painted
        add_cmd(REQ_DRAW, -8388608, -8388608, 8388607, 8388607, 0, 8'h52, 0, 0);
        known_rsp(0, STAT_OK);
        add_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0);                   known_rsp(255, STAT_OK);
        add_reg(CFG_FRAME_WIDTH, 8);
        add_reg(CFG_FRAME_HEIGHT, 6);
        add_reg(CFG_BACKGROUND, 0);
        add_cmd(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(REQ_DRAW, 'h180, 0, 'h200, 'h300, 0, 8'h52, 0, 0);   // 'R' filled
        add_cmd(REQ_DRAW, 'h100, 'h080, 'h500, 'h400, 1, 8'h72, 0, 0); // 'r' outline
        add_cmd(REQ_DRAW, 8388607, 8388607, 8388607, 8388607, 1, 255, 0, 0);
        add_cmd(REQ_DRAW, -'h100, -'h100, 'h900, 'h700, 1, 1, 0, 0);
        add_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 7, 5);
        add_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 2, 1);
        add_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 3, 2);
        add_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 8, 0);                   known_rsp(0, STAT_OUTSIDE);
        add_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 6);                   known_rsp(0, STAT_OUTSIDE);
        add_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 255, 255);               known_rsp(0, STAT_OUTSIDE);
        // fractional corner: covers only the pixel at (1,1)
        add_cmd(REQ_DRAW, 'h0FF, 'h0FF, 1, 2, 0, 8'hAA, 0, 0);
        add_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 1, 1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
        begin
            if (plan_q[i].is_reg)
            begin
                if (!cfg_we)
                    wait_idle();
                reg_write(plan_q[i].addr, plan_q[i].val);
            end
            else
            begin
                if (cfg_we)
                    cfg_we <= 1'b0;
                issue_cmd(plan_q[i].c, plan_q[i].fixed, plan_q[i].rsp, 15);
            end
        end

        // each phase: new window, clear first so every read inside the window hits a written cell
        phase = 0;
        while (sent < RAND_ITEMS)
        begin
            case (phase)
                1:       begin w = 511; h = 1;   n = 8; end
                2:       begin w = 0;   h = 256; n = 8; end
                3:       begin w = 256; h = 256; n = 4; end
                default:
                begin
                    w = $urandom_range(0, 20);
                    h = $urandom_range(0, 20);
                    n = $urandom_range(8, 14);
                end
            endcase
            set_window(w, h, $urandom_range(0, 255));
            for (int k = 0; k < n; k++)
            begin
                pct = (sent < RAND_ITEMS / 3) ? 15 : (sent < 2 * RAND_ITEMS / 3) ? 52 : 0;
                issue_cmd(random_cmd(k == 0), 1'b0, none, pct);
                sent++;
            end
            phase++;
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("rectangle_raster_painter test passed");
        else
            $display("rectangle_raster_painter test failed");
        $finish;
    end

endmodule
